### hdl/pmst_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and codes for the MST cost engine.
// Used by pmst_ctrl, pmst_dp, prim_mst_cost and pmst_checker.
package pmst_pkg;

    localparam int MAX_NODES  = 16;
    localparam int CELLS      = MAX_NODES * MAX_NODES;
    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int CNT_W      = $clog2(MAX_NODES + 1);
    localparam int CELL_W     = $clog2(CELLS);
    localparam int LIDX_W     = $clog2(CELLS + 1);
    localparam int NC_W       = 5;
    localparam int SN_W       = 4;
    localparam int CMP_W      = (CNT_W > NC_W) ? CNT_W : NC_W;
    localparam int WEIGHT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_NODE = 2'd1;

    localparam logic [NC_W-1:0]     NODE_COUNT_RST = 5'd16;
    localparam logic [SN_W-1:0]     START_NODE_RST = 4'd0;
    localparam logic [WEIGHT_W-1:0] NO_EDGE_COST   = 32'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_DRAIN,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_we;
        logic init;
        logic scan_issue;
        logic round_update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic init_stop;
        logic scan_last;
        logic found;
        logic round_last;
        logic out_free;
    } status_t;

endpackage

### hdl/prim_mst_cost.sv
`timescale 1ns / 1ps
// Top level of the MST cost engine: joins pmst_ctrl and pmst_dp.
// Depends on pmst_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) takes one adjacency matrix entry
//   per request, row-major (from, to): edge_weight, edge_connected and
//   last_entry. Loading runs at one entry per cycle while in_stall is low.
//   The request with last_entry set starts the search. in_stall stays high
//   until the result is placed in the output register.
//   Search: up to node_count - 1 rounds; each round reads all
//   node_count * node_count matrix entries through the single memory read
//   port, one per cycle, then passes through the drain and round-update
//   states. Fewer rounds run if the graph is disconnected or start_node is
//   out of range.
//   Output channel (out_valid / out_stall) holds total_cost until taken;
//   loading of the next matrix goes on while a result waits.
//   Config channel (cfg_valid / cfg_ready) writes node_count (index 0) and
//   start_node (index 1); write only while the block is idle.
//   Reset: node_count = 16, start_node = 0, load position at entry zero,
//   no result pending. No clearing pass is needed.
module prim_mst_cost
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [pmst_pkg::WEIGHT_W-1:0] edge_weight,
    input  logic                                 edge_connected,
    input  logic                                 last_entry,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pmst_pkg::WEIGHT_W-1:0] total_cost,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmst_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pmst_pkg::cmd_t    cmd;
    pmst_pkg::status_t status;

    pmst_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last_entry (last_entry),
        .status     (status),
        .cmd        (cmd),
        .in_stall   (in_stall)
    );

    pmst_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .edge_weight    (edge_weight),
        .edge_connected (edge_connected),
        .last_entry     (last_entry),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .total_cost     (total_cost)
    );

endmodule

### hdl/pmst_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the MST cost engine: load, init, scan rounds, finish.
// Depends on pmst_pkg; drives commands into pmst_dp.
module pmst_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             last_entry,
    input  pmst_pkg::status_t status,
    output pmst_pkg::cmd_t   cmd,
    output logic             in_stall
);

    pmst_pkg::state_t state_reg;
    pmst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmst_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmst_pkg::ST_LOAD:
            begin
                if (in_valid && last_entry)
                begin
                    state_next = pmst_pkg::ST_INIT;
                end
            end
            pmst_pkg::ST_INIT:
            begin
                state_next = status.init_stop ? pmst_pkg::ST_FINISH : pmst_pkg::ST_SCAN;
            end
            pmst_pkg::ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = pmst_pkg::ST_DRAIN;
                end
            end
            pmst_pkg::ST_DRAIN:
            begin
                state_next = pmst_pkg::ST_ROUND;
            end
            pmst_pkg::ST_ROUND:
            begin
                if (!status.found || status.round_last)
                begin
                    state_next = pmst_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = pmst_pkg::ST_SCAN;
                end
            end
            pmst_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = pmst_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = pmst_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            pmst_pkg::ST_LOAD:
            begin
                in_stall    = 1'b0;
                cmd.load_we = in_valid;
            end
            pmst_pkg::ST_INIT:
            begin
                cmd.init = 1'b1;
            end
            pmst_pkg::ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            pmst_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            pmst_pkg::ST_ROUND:
            begin
                cmd.round_update = status.found;
            end
            pmst_pkg::ST_FINISH:
            begin
                cmd.out_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### hdl/pmst_dp.sv
`timescale 1ns / 1ps
// Datapath of the MST cost engine: matrix memory, scan counters,
// best-edge compare, visited marks, cost sum, config and output registers.
// Depends on pmst_pkg; commanded by pmst_ctrl.
module pmst_dp
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pmst_pkg::cmd_t                       cmd,
    output pmst_pkg::status_t                    status,
    input  logic signed [pmst_pkg::WEIGHT_W-1:0] edge_weight,
    input  logic                                 edge_connected,
    input  logic                                 last_entry,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pmst_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pmst_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [pmst_pkg::WEIGHT_W-1:0] total_cost
);

    logic [pmst_pkg::NC_W-1:0]      node_count_reg;
    logic [pmst_pkg::SN_W-1:0]      start_node_reg;
    logic [pmst_pkg::LIDX_W-1:0]    load_index_reg;
    logic [pmst_pkg::WEIGHT_W:0]    mem [pmst_pkg::CELLS];
    logic [pmst_pkg::WEIGHT_W:0]    rd_data_reg;
    logic                           rd_valid_reg;
    logic [pmst_pkg::NODE_W-1:0]    rd_from_reg;
    logic [pmst_pkg::NODE_W-1:0]    rd_to_reg;
    logic [pmst_pkg::NODE_W-1:0]    from_reg;
    logic [pmst_pkg::NODE_W-1:0]    to_reg;
    logic [pmst_pkg::NODE_W-1:0]    round_reg;
    logic [pmst_pkg::NODE_W-1:0]    pick_reg;
    logic [pmst_pkg::WEIGHT_W-1:0]  best_reg;
    logic                           found_reg;
    logic [pmst_pkg::MAX_NODES-1:0] visited_reg;
    logic [pmst_pkg::WEIGHT_W-1:0]  cost_reg;
    logic                           out_valid_reg;
    logic [pmst_pkg::WEIGHT_W-1:0]  total_cost_reg;

    logic [pmst_pkg::CNT_W-1:0]     n_eff;
    logic                           start_bad;
    logic [pmst_pkg::NODE_W-1:0]    start_idx;
    logic [pmst_pkg::CELL_W-1:0]    rd_addr;
    logic                           to_last;
    logic                           from_last;
    logic [pmst_pkg::CNT_W:0]       round_plus2;
    logic [pmst_pkg::WEIGHT_W-1:0]  rd_weight;
    logic                           rd_link;
    logic                           hit;
    logic                           store_we;

    assign cfg_ready = 1'b1;

    assign n_eff = (pmst_pkg::CMP_W'(node_count_reg) > pmst_pkg::CMP_W'(pmst_pkg::MAX_NODES))
                 ? pmst_pkg::CNT_W'(pmst_pkg::MAX_NODES)
                 : pmst_pkg::CNT_W'(node_count_reg);
    assign start_bad = pmst_pkg::CMP_W'(start_node_reg) >= pmst_pkg::CMP_W'(n_eff);
    assign start_idx = pmst_pkg::NODE_W'(start_node_reg);

    assign rd_addr = pmst_pkg::CELL_W'(from_reg) * pmst_pkg::CELL_W'(n_eff)
                   + pmst_pkg::CELL_W'(to_reg);
    assign to_last   = (pmst_pkg::CNT_W'(to_reg) + pmst_pkg::CNT_W'(1)) == n_eff;
    assign from_last = (pmst_pkg::CNT_W'(from_reg) + pmst_pkg::CNT_W'(1)) == n_eff;
    assign round_plus2 = (pmst_pkg::CNT_W + 1)'(round_reg) + (pmst_pkg::CNT_W + 1)'(2);

    assign rd_weight = rd_data_reg[pmst_pkg::WEIGHT_W-1:0];
    assign rd_link   = rd_data_reg[pmst_pkg::WEIGHT_W];
    assign hit = rd_valid_reg && rd_link && visited_reg[rd_from_reg] && !visited_reg[rd_to_reg]
              && ($signed(rd_weight) < $signed(best_reg));

    assign store_we = cmd.load_we && (load_index_reg < pmst_pkg::LIDX_W'(pmst_pkg::CELLS));

    assign status.init_stop  = start_bad || (n_eff <= pmst_pkg::CNT_W'(1));
    assign status.scan_last  = from_last && to_last;
    assign status.found      = found_reg;
    assign status.round_last = round_plus2 >= (pmst_pkg::CNT_W + 1)'(n_eff);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            mem[load_index_reg[pmst_pkg::CELL_W-1:0]] <= {edge_connected, edge_weight};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= pmst_pkg::NODE_COUNT_RST;
            start_node_reg <= pmst_pkg::START_NODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pmst_pkg::CFG_NODE_COUNT: node_count_reg <= pmst_pkg::NC_W'(cfg_data);
                pmst_pkg::CFG_START_NODE: start_node_reg <= pmst_pkg::SN_W'(cfg_data);
                default:                  node_count_reg <= node_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_index_reg <= '0;
        end
        else if (cmd.load_we)
        begin
            if (last_entry)
            begin
                load_index_reg <= '0;
            end
            else if (store_we)
            begin
                load_index_reg <= load_index_reg + pmst_pkg::LIDX_W'(1);
            end
        end
    end

    // advance the scan; restart it at each new round
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            from_reg     <= '0;
            to_reg       <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_issue;
            if (cmd.init || cmd.round_update)
            begin
                from_reg <= '0;
                to_reg   <= '0;
            end
            else if (cmd.scan_issue)
            begin
                if (to_last)
                begin
                    to_reg   <= '0;
                    from_reg <= from_reg + pmst_pkg::NODE_W'(1);
                end
                else
                begin
                    to_reg <= to_reg + pmst_pkg::NODE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_from_reg <= from_reg;
        rd_to_reg   <= to_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg    <= pmst_pkg::NO_EDGE_COST;
            found_reg   <= 1'b0;
            pick_reg    <= '0;
            visited_reg <= '0;
            cost_reg    <= '0;
            round_reg   <= '0;
        end
        else if (cmd.init)
        begin
            best_reg    <= pmst_pkg::NO_EDGE_COST;
            found_reg   <= 1'b0;
            cost_reg    <= '0;
            round_reg   <= '0;
            visited_reg <= start_bad ? '0 : (pmst_pkg::MAX_NODES'(1) << start_idx);
        end
        else if (cmd.round_update)
        begin
            best_reg              <= pmst_pkg::NO_EDGE_COST;
            found_reg             <= 1'b0;
            cost_reg              <= cost_reg + best_reg;
            round_reg             <= round_reg + pmst_pkg::NODE_W'(1);
            visited_reg[pick_reg] <= 1'b1;
        end
        else if (hit)
        begin
            best_reg  <= rd_weight;
            found_reg <= 1'b1;
            pick_reg  <= rd_to_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            total_cost_reg <= cost_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign total_cost = $signed(total_cost_reg);

endmodule

### hdl/pmst_checker.sv
`timescale 1ns / 1ps
// Port-level checks for prim_mst_cost, attached by bind.
// Depends on pmst_pkg.
module pmst_checker
(
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 last_entry,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [pmst_pkg::WEIGHT_W-1:0] total_cost
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(total_cost))
        else $error("result changed while stalled");

    a_search_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_entry |=> in_stall)
        else $error("input taken during search");

    a_result_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a search");

endmodule

bind prim_mst_cost pmst_checker u_pmst_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last_entry (last_entry),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .total_cost (total_cost)
);
